/* sv/c3vs_pkg.sv */
`timescale 1ns / 1ps

package c3vs_pkg;

   // Field widths.
   localparam int PIX_W      = 16;
   localparam int COEF_W     = 48;
   localparam int KSIZE      = 3;
   localparam int TAPS       = KSIZE * KSIZE;
   localparam int PROD_W     = 2 * PIX_W;
   localparam int ROWSUM_W   = PROD_W + 2;
   localparam int SUM_W      = 40;
   localparam int TAG_W      = 12;
   localparam int BIAS_SHIFT = 8;
   localparam int CSR_IDX_W  = 2;

   // Default image size.
   localparam int IMG_WIDTH_DEF  = 8;
   localparam int IMG_HEIGHT_DEF = 8;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TOP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_MID = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BOT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS     = 2'd3;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [TAPS-1:0] win_type;
   typedef logic [KSIZE-1:0][COEF_W-1:0] coef_rows_type;

   // Position tag that travels with each item.
   typedef struct packed {
      logic [TAG_W-1:0] row;
      logic [TAG_W-1:0] col;
      logic             last;
   } tag_type;

endpackage

/* sv/c3vs_line_store.sv */
`timescale 1ns / 1ps

module c3vs_line_store #(
   parameter int DEPTH = c3vs_pkg::IMG_WIDTH_DEF,
   parameter int WIDTH = 2 * c3vs_pkg::PIX_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/c3vs_window.sv */
`timescale 1ns / 1ps

module c3vs_window #(
   parameter int IMG_WIDTH  = c3vs_pkg::IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = c3vs_pkg::IMG_HEIGHT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  logic [c3vs_pkg::PIX_W-1:0] pixel,
   input  logic                    down_ready,
   output logic                    win_valid,
   output c3vs_pkg::win_type       win,
   output c3vs_pkg::tag_type       tag
);

   localparam int COL_W = $clog2(IMG_WIDTH);
   localparam int ROW_W = $clog2(IMG_HEIGHT);
   localparam int K     = c3vs_pkg::KSIZE;
   localparam int PW    = c3vs_pkg::PIX_W;

   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic             accept;
   logic             col_last;
   logic             row_last;
   logic             complete;
   logic [2*PW-1:0]  rd_data;
   logic [COL_W-1:0] rd_addr;

   c3vs_pkg::pix_type column [K];
   c3vs_pkg::pix_type wreg_ff [K][2];

   logic              win_valid_ff;
   c3vs_pkg::win_type win_ff, win_in;
   c3vs_pkg::tag_type tag_ff, tag_in;

   // Stage is free when empty or when the next stage takes its item.
   assign in_stall = win_valid_ff && !down_ready;
   assign accept   = in_valid && !in_stall;

   // Raster position of the next pixel.
   assign col_last = (col_count_ff == COL_W'(IMG_WIDTH - 1));
   assign row_last = (row_count_ff == ROW_W'(IMG_HEIGHT - 1));

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (col_last) begin
            col_count_in = '0;
            row_count_in = row_last ? '0 : row_count_ff + ROW_W'(1);
         end else begin
            col_count_in = col_count_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // Line store: low half is the row two above, high half the row above.
   // The read runs one column ahead so data is ready when the pixel comes.
   assign rd_addr = col_count_in;

   c3vs_line_store #(
      .DEPTH (IMG_WIDTH),
      .WIDTH (2 * PW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_count_ff),
      .wr_data ({pixel, rd_data[2*PW-1:PW]}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Newest column of the window, top first.
   always_comb begin
      column[0] = rd_data[PW-1:0];
      column[1] = rd_data[2*PW-1:PW];
      column[2] = pixel;
   end

   // Window shift registers for the two older columns.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < K; i++) begin
            wreg_ff[i][0] <= wreg_ff[i][1];
            wreg_ff[i][1] <= column[i];
         end
      end
   end

   // Full window and its position tag.
   assign complete = (row_count_ff >= ROW_W'(2)) && (col_count_ff >= COL_W'(2));

   always_comb begin
      for (int i = 0; i < K; i++) begin
         win_in[i*K]     = wreg_ff[i][0];
         win_in[i*K + 1] = wreg_ff[i][1];
         win_in[i*K + 2] = column[i];
      end
      tag_in.row  = c3vs_pkg::TAG_W'(row_count_ff - ROW_W'(2));
      tag_in.col  = c3vs_pkg::TAG_W'(col_count_ff - COL_W'(2));
      tag_in.last = row_last && col_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= 1'b0;
      end else if (!in_stall) begin
         win_valid_ff <= accept && complete;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
         tag_ff <= tag_in;
      end
   end

   assign win_valid = win_valid_ff;
   assign win       = win_ff;
   assign tag       = tag_ff;

endmodule

/* sv/c3vs_mac.sv */
`timescale 1ns / 1ps

module c3vs_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  c3vs_pkg::win_type                   win,
   input  c3vs_pkg::tag_type                   tag,
   input  c3vs_pkg::coef_rows_type             coef_rows,
   input  logic signed [c3vs_pkg::PIX_W-1:0]   bias,
   output logic                                out_valid,
   input  logic                                out_stall,
   output logic signed [c3vs_pkg::SUM_W-1:0]   out_sum,
   output c3vs_pkg::tag_type                   out_tag
);

   localparam int K    = c3vs_pkg::KSIZE;
   localparam int PW   = c3vs_pkg::PIX_W;
   localparam int PRW  = c3vs_pkg::PROD_W;
   localparam int RSW  = c3vs_pkg::ROWSUM_W;
   localparam int SW   = c3vs_pkg::SUM_W;

   logic en_b, en_c, en_d;
   logic vb_ff, vc_ff, vd_ff;

   logic signed [PRW-1:0] prod_ff [c3vs_pkg::TAPS];
   logic signed [PRW-1:0] prod_in [c3vs_pkg::TAPS];
   logic signed [RSW-1:0] rsum_ff [K];
   logic signed [RSW-1:0] rsum_in [K];
   logic signed [SW-1:0]  sum_ff, sum_in;

   c3vs_pkg::tag_type tag_b_ff, tag_c_ff, tag_d_ff;

   // Each stage moves when empty or when the stage after it moves.
   assign en_d     = !vd_ff || !out_stall;
   assign en_c     = !vc_ff || en_d;
   assign en_b     = !vb_ff || en_c;
   assign in_ready = en_b;

   // Nine parallel products.
   always_comb begin
      for (int i = 0; i < K; i++) begin
         for (int j = 0; j < K; j++) begin
            prod_in[i*K + j] = PRW'($signed(win[i*K + j]))
                             * PRW'($signed(coef_rows[i][j*PW +: PW]));
         end
      end
   end

   // Sum of each kernel row.
   always_comb begin
      for (int i = 0; i < K; i++) begin
         rsum_in[i] = RSW'(prod_ff[i*K]) + RSW'(prod_ff[i*K + 1]) + RSW'(prod_ff[i*K + 2]);
      end
   end

   // Final sum with the bias aligned to 16 fraction bits.
   assign sum_in = SW'(rsum_ff[0]) + SW'(rsum_ff[1]) + SW'(rsum_ff[2])
                 + (SW'(bias) <<< c3vs_pkg::BIAS_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (en_b) begin
            vb_ff <= in_valid;
         end
         if (en_c) begin
            vc_ff <= vb_ff;
         end
         if (en_d) begin
            vd_ff <= vc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_b && in_valid) begin
         prod_ff  <= prod_in;
         tag_b_ff <= tag;
      end
      if (en_c && vb_ff) begin
         rsum_ff  <= rsum_in;
         tag_c_ff <= tag_b_ff;
      end
      if (en_d && vc_ff) begin
         sum_ff   <= sum_in;
         tag_d_ff <= tag_c_ff;
      end
   end

   assign out_valid = vd_ff;
   assign out_sum   = sum_ff;
   assign out_tag   = tag_d_ff;

endmodule

/* sv/conv3x3_valid_stream_top.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  req_pixel
// rsp      out        rsp_valid / rsp_stall  rsp_sum, rsp_out_row, rsp_out_col, rsp_frame_last
// csr      in         csr_write_en           csr_index, csr_wdata
//
// One pixel is accepted every cycle while req_stall is low; a result reaches the
// outputs after passing the window register, the product register, the row sum
// register and the output register. The line store read runs one column ahead.
// Reset clears the counters, the stage valid bits and the configuration registers.
// A stalled result holds its stage; earlier stages keep filling bubbles
// before req_stall rises.

module conv3x3_valid_stream_top #(
   parameter int IMG_WIDTH  = c3vs_pkg::IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = c3vs_pkg::IMG_HEIGHT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [c3vs_pkg::PIX_W-1:0]     req_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [c3vs_pkg::SUM_W-1:0]     rsp_sum,
   output logic [c3vs_pkg::TAG_W-1:0]            rsp_out_row,
   output logic [c3vs_pkg::TAG_W-1:0]            rsp_out_col,
   output logic                                  rsp_frame_last,
   input  logic                                  csr_write_en,
   input  logic [c3vs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [c3vs_pkg::COEF_W-1:0]           csr_wdata
);

   c3vs_pkg::coef_rows_type           coef_rows_ff;
   logic signed [c3vs_pkg::PIX_W-1:0] bias_ff;

   logic              mac_ready;
   logic              win_valid;
   c3vs_pkg::win_type win;
   c3vs_pkg::tag_type win_tag;
   c3vs_pkg::tag_type rsp_tag;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_rows_ff <= '0;
         bias_ff      <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            c3vs_pkg::CSR_COEF_TOP: coef_rows_ff[0] <= csr_wdata;
            c3vs_pkg::CSR_COEF_MID: coef_rows_ff[1] <= csr_wdata;
            c3vs_pkg::CSR_COEF_BOT: coef_rows_ff[2] <= csr_wdata;
            c3vs_pkg::CSR_BIAS:     bias_ff <= csr_wdata[c3vs_pkg::PIX_W-1:0];
            default:                bias_ff <= bias_ff;
         endcase
      end
   end

   // Window builder with its line store.
   c3vs_window #(
      .IMG_WIDTH  (IMG_WIDTH),
      .IMG_HEIGHT (IMG_HEIGHT)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .pixel      (req_pixel),
      .down_ready (mac_ready),
      .win_valid  (win_valid),
      .win        (win),
      .tag        (win_tag)
   );

   // Multiply and accumulate stages.
   c3vs_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .in_ready  (mac_ready),
      .win       (win),
      .tag       (win_tag),
      .coef_rows (coef_rows_ff),
      .bias      (bias_ff),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_sum   (rsp_sum),
      .out_tag   (rsp_tag)
   );

   assign rsp_out_row    = rsp_tag.row;
   assign rsp_out_col    = rsp_tag.col;
   assign rsp_frame_last = rsp_tag.last;

   // The frame mark sits only on the bottom right window.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |->
         rsp_out_row == (IMG_HEIGHT - 3) && rsp_out_col == (IMG_WIDTH - 3))
      else $error("frame mark on a window that is not the last one");

   // Result positions stay inside the valid output area.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_row <= (IMG_HEIGHT - 3) && rsp_out_col <= (IMG_WIDTH - 3))
      else $error("result position outside the output area");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule
